### design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, codes and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] PadChar = 8'h3d;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusLength  = 2'd1,
    StatusBadChar = 2'd2
  } status_e;

  // One queue entry: an optional data beat and an optional status beat
  typedef struct packed {
    logic    data_vld;
    logic [7:0] data;
    logic    stat_vld;
    status_e status;
  } op_t;

  // Returns {invalid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/b64d_front.sv
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each character, tracks group state and forms queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64d_front import b64d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       final_char_i,
  input  wire logic       full_i,
  output logic            push_o,
  output op_t             op_o
);

  logic [1:0] group_pos_q, group_pos_d;
  logic [5:0] held_q, held_d;
  logic [1:0] len_q, len_d;
  logic       pad_q, pad_d;
  logic       bad_q, bad_d;

  logic       accept;
  logic [6:0] sx;
  logic       emit;
  logic [7:0] byte_val;
  logic       bad_next;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign sx         = sextet_of(char_code_i);

  always_comb begin
    unique case (group_pos_q)
      2'd1:    byte_val = {held_q, sx[5:4]};
      2'd2:    byte_val = {held_q[3:0], sx[5:2]};
      2'd3:    byte_val = {held_q[1:0], sx[5:0]};
      default: byte_val = 8'h00;
    endcase
  end

  always_comb begin
    group_pos_d = group_pos_q;
    held_d      = held_q;
    len_d       = len_q + 2'd1;
    pad_d       = pad_q;
    bad_d       = bad_q;
    emit        = 1'b0;
    if (!pad_q && !bad_q) begin
      if (char_code_i == PadChar) begin
        pad_d = 1'b1;
      end else if (sx[6]) begin
        bad_d = 1'b1;
      end else begin
        emit        = (group_pos_q != 2'd0);
        held_d      = sx[5:0];
        group_pos_d = group_pos_q + 2'd1;
      end
    end
    bad_next = bad_d;
    // end of string: clear everything for the next one
    if (final_char_i) begin
      group_pos_d = 2'd0;
      held_d      = 6'd0;
      len_d       = 2'd0;
      pad_d       = 1'b0;
      bad_d       = 1'b0;
    end
  end

  always_comb begin
    op_o.data_vld = emit;
    op_o.data     = byte_val;
    op_o.stat_vld = final_char_i;
    if ((len_q + 2'd1) != 2'd0) begin
      op_o.status = StatusLength;
    end else if (bad_next) begin
      op_o.status = StatusBadChar;
    end else begin
      op_o.status = StatusOk;
    end
  end

  assign push_o = accept && (emit || final_char_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_pos_q <= 2'd0;
      held_q      <= 6'd0;
      len_q       <= 2'd0;
      pad_q       <= 1'b0;
      bad_q       <= 1'b0;
    end else if (accept) begin
      group_pos_q <= group_pos_d;
      held_q      <= held_d;
      len_q       <= len_d;
      pad_q       <= pad_d;
      bad_q       <= bad_d;
    end
  end

endmodule

`default_nettype wire

### design/b64d_fifo.sv
// ----------------------------------------------------------------------------
// Base64 decoder queue
// Short register queue of decoded entries between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64d_fifo import b64d_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output op_t       op_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  op_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

### design/b64d_back.sv
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Takes queue entries and drives them out as data and status beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64d_back import b64d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire op_t        op_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [7:0]      data_byte_o,
  output logic [1:0]      status_o,
  output logic            end_mark_o
);

  logic       data_pend_q, data_pend_d;
  logic       stat_pend_q, stat_pend_d;
  logic [7:0] data_q;
  status_e    status_q;
  logic       both;
  logic       load;

  assign both  = data_pend_q && stat_pend_q;
  assign out_valid_o = data_pend_q || stat_pend_q;
  assign load  = !out_valid_o || (out_ready_i && !both);
  assign pop_o = load && !empty_i;

  always_comb begin
    data_pend_d = data_pend_q;
    stat_pend_d = stat_pend_q;
    if (out_ready_i && both) begin
      // data beat goes first, status beat stays
      data_pend_d = 1'b0;
    end else if (load) begin
      data_pend_d = !empty_i && op_i.data_vld;
      stat_pend_d = !empty_i && op_i.stat_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_pend_q <= 1'b0;
      stat_pend_q <= 1'b0;
    end else begin
      data_pend_q <= data_pend_d;
      stat_pend_q <= stat_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q   <= op_i.data;
      status_q <= op_i.status;
    end
  end

  assign kind_o      = data_pend_q ? KindData : KindStatus;
  assign data_byte_o = data_pend_q ? data_q : 8'h00;
  assign status_o    = data_pend_q ? 2'(StatusOk) : 2'(status_q);
  assign end_mark_o  = !data_pend_q && stat_pend_q;

endmodule

`default_nettype wire

### design/base64_decoder.sv
// Each accepted entry is queued, then registered in the back end as its result beat.
// Throughput: one character per cycle while the queue has room; a final character that
// also yields a data byte takes a data beat and a status beat, absorbed by the queue.
// Queue depth (QueueDepth entries) sets how far the input runs ahead of a stalled output.
// Reset: rst_ni clears group state, queue pointers and output valid at once.
// ----------------------------------------------------------------------------
// Base64 decoder top level
// Character-per-beat RFC 4648 decoder with data and end-status result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_decoder import b64d_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       final_char_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [7:0]      data_byte_o,
  output logic [1:0]      status_o,
  output logic            end_mark_o
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  op_t  op_in;
  op_t  op_out;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .final_char_i (final_char_i),
    .full_i       (full),
    .push_o       (push),
    .op_o         (op_in)
  );

  b64d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .op_o    (op_out)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .op_i        (op_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .status_o    (status_o),
    .end_mark_o  (end_mark_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");

  a_data_beat_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindData) |-> (status_o == 2'(StatusOk) && !end_mark_o))
    else $error("data beat carries status");

  a_status_beat_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindStatus) |-> (end_mark_o && data_byte_o == 8'h00
      && status_o != 2'd3))
    else $error("malformed status beat");

endmodule

`default_nettype wire
